/* hw/rtl/sorted_priority_queue_unit_macros.svh */
// Assertion macros for the sorted priority queue unit.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Checked only outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int KEY_W        = 31;
  localparam int PAY_W        = 32;
  localparam int OP_W         = 2;
  localparam int ST_W         = 2;
  localparam int OCC_W        = 5;
  localparam int DEF_CAPACITY = 16;

  localparam logic [OP_W-1:0] OP_ENQ   = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLR   = 2'd2;
  localparam logic [OP_W-1:0] OP_COUNT = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [KEY_W-1:0] entry_key;
    logic [PAY_W-1:0] entry_payload;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [KEY_W-1:0] removed_key;
    logic [PAY_W-1:0] removed_payload;
    logic [OCC_W-1:0] occupancy;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } slot_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic enq;
    logic deq;
    logic clr;
  } ctrl_t;

endpackage

/* hw/rtl/spq_cell.sv */
// One slot of the sorted shift chain: holds an entry, shifts or inserts.
module spq_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  spq_pkg::ctrl_t ctrl,
  input  spq_pkg::slot_t new_entry,
  input  spq_pkg::slot_t left,
  input  logic           left_keep,
  input  spq_pkg::slot_t right,
  output spq_pkg::slot_t own,
  output logic           keep
);
  import spq_pkg::*;

  logic             valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [PAY_W-1:0] pay_r, pay_nxt;

  assign own  = '{valid: valid_r, key: key_r, payload: pay_r};
  // Entry stays put on insert when its key is not above the new key.
  assign keep = valid_r && (key_r <= new_entry.key);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    pay_nxt   = pay_r;
    if (ctrl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctrl.enq && !keep) begin
      if (left_keep) begin
        valid_nxt = 1'b1;
        key_nxt   = new_entry.key;
        pay_nxt   = new_entry.payload;
      end else begin
        valid_nxt = left.valid;
        key_nxt   = left.key;
        pay_nxt   = left.payload;
      end
    end else if (ctrl.deq) begin
      valid_nxt = right.valid;
      key_nxt   = right.key;
      pay_nxt   = right.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pay_r <= pay_nxt;
  end

endmodule

/* hw/rtl/sorted_priority_queue_unit.sv */
// Sorted priority queue: top level with the cell chain and result register.
// The result of each input transaction is registered in the output register.
// Throughput: one operation per cycle while the input is not stalled; every cell compares and shifts in parallel.
// The input stalls only while a finished result waits under output stall.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result;
// slot contents are not cleared, only their valid flags.
`include "sorted_priority_queue_unit_macros.svh"

module sorted_priority_queue_unit #(
  parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output spq_pkg::out_item_t out_data
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Chain state
  slot_t                slots [CAPACITY];
  logic [CAPACITY-1:0]  keep_vec;
  logic [CAPACITY-1:0]  valid_vec;
  ctrl_t                ctrl;
  slot_t                new_entry;

  logic                 accept;
  logic                 full, empty;
  logic                 enq_ok, deq_ok;

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W+OCC_W-1:0] count_ext;

  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  // A transaction is taken unless a result is held back by the consumer.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full  = slots[CAPACITY-1].valid;
  assign empty = !slots[0].valid;

  assign enq_ok = accept && (in_data.opcode == OP_ENQ) && !full;
  assign deq_ok = accept && (in_data.opcode == OP_DEQ) && !empty;

  assign ctrl = '{enq: enq_ok, deq: deq_ok, clr: accept && (in_data.opcode == OP_CLR)};
  assign new_entry = '{valid: 1'b1, key: in_data.entry_key, payload: in_data.entry_payload};

  // Cell chain: slot 0 is the head (smallest key, oldest among equals).
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t left_s, right_s;
    logic  left_k;

    if (i == 0) begin : g_head
      assign left_s = '0;
      assign left_k = 1'b1;   // head has nothing in front: insert here if not kept
    end else begin : g_body
      assign left_s = slots[i-1];
      assign left_k = keep_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_s = '0;    // empty slot shifts in behind on dequeue
    end else begin : g_mid
      assign right_s = slots[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .new_entry (new_entry),
      .left      (left_s),
      .left_keep (left_k),
      .right     (right_s),
      .own       (slots[i]),
      .keep      (keep_vec[i])
    );

    assign valid_vec[i] = slots[i].valid;
  end

  // Occupancy counter mirrors the chain's valid flags.
  always_comb begin
    count_nxt = count_r;
    if (ctrl.clr) begin
      count_nxt = '0;
    end else if (enq_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (deq_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Occupancy field carries the low bits of the count.
  assign count_ext = {{OCC_W{1'b0}}, count_nxt};

  always_comb begin
    out_data_nxt                 = '0;
    out_data_nxt.status          = ST_OK;
    out_data_nxt.occupancy       = count_ext[OCC_W-1:0];
    case (in_data.opcode)
      OP_ENQ: begin
        if (full) begin
          out_data_nxt.status = ST_FULL;
        end
      end
      OP_DEQ: begin
        if (empty) begin
          out_data_nxt.status = ST_EMPTY;
        end else begin
          out_data_nxt.removed_key     = slots[0].key;
          out_data_nxt.removed_payload = slots[0].payload;
        end
      end
      OP_CLR:   out_data_nxt.status = ST_OK;
      OP_COUNT: out_data_nxt.status = ST_OK;
      default:  out_data_nxt.status = ST_OK;
    endcase
  end

  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: loaded only when a transaction is taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  logic sorted_ok;

  always_comb begin
    sorted_ok = 1'b1;
    for (int j = 0; j < CAPACITY - 1; j++) begin
      if (slots[j+1].valid && (slots[j].key > slots[j+1].key)) begin
        sorted_ok = 1'b0;
      end
    end
  end

  `SPQ_ASSERT(a_valid_packed, ((valid_vec & (valid_vec + 1'b1)) == '0), "valid slots not packed at head")
  `SPQ_ASSERT(a_count_match, (32'(count_r) == $countones(valid_vec)), "count differs from valid slots")
  `SPQ_ASSERT(a_keys_sorted, sorted_ok, "stored keys out of order")
  `SPQ_ASSERT(a_deq_ok, (deq_ok |=> (out_valid && (out_data.status == ST_OK))), "dequeue result lost")
  `SPQ_ASSERT_ALWAYS(a_reset_idle, (!rst_n |=> !out_valid), "result pending after reset")

endmodule
